// ===== hw/rtl/fsd_pkg.sv =====
// Shared types and constants of the force/torque decoupling block.
// Used by every module under hw/rtl except fsd_ram; depends on nothing.
`default_nettype none

package fsd_pkg;

	localparam int AXES         = 6;   // wrench components
	localparam int COUNT_FIELDS = 6;   // gauge count ports on the input word
	localparam int INDEX_W      = 6;
	localparam int VALUE_W      = 32;
	localparam int COUNT_IN_W   = 16;
	localparam int OUT_W        = 32;
	localparam int FRAC_DROP    = 16;  // Q.24 products down to Q24.8
	localparam int GUARD_W      = 3;   // growth for up to eight summed products

	localparam int CHANNELS_DEF   = 6;
	localparam int COUNT_BITS_DEF = 16;

	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_TARE    = 2'd1,
		FUNC_MEASURE = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	// Accumulate-stage control broadcast to every axis lane.
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/force_torque_decoupling.sv =====
// Top level of the six-axis force/torque decoupling block.
// Depends on fsd_pkg, fsd_ram, fsd_lane and fsd_merge.
//
// Each input word yields one output word. Load words write one coefficient
// (indexes 0 to 6*CHANNELS-1, row-major by axis) or one channel zero (the next
// CHANNELS indexes) and return an all-zero word; an entry must be written
// before any tare or measure word uses it. Tare words capture the rounded,
// saturated wrench as the new offset and return it; measure words return the
// wrench minus that offset, saturated to 32 bits. Six axis lanes run side by
// side, each stepping its one multiplier through the min(CHANNELS, 6) gauge
// columns (six at the defaults), so a new word is taken only when the engine is
// idle or reading the last column of the word before, and only while fewer than
// two words are in the block. Up to two words may be in the block before the
// output side must drain one.
`default_nettype none

module force_torque_decoupling #(
	parameter int CHANNELS   = fsd_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = fsd_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           func,
	input  wire logic [fsd_pkg::INDEX_W-1:0]          table_index,
	input  wire logic signed [fsd_pkg::VALUE_W-1:0]   table_value,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch0,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch1,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch2,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch3,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch4,
	input  wire logic [fsd_pkg::COUNT_IN_W-1:0]       count_ch5,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [fsd_pkg::OUT_W-1:0]          force_x,
	output logic signed [fsd_pkg::OUT_W-1:0]          force_y,
	output logic signed [fsd_pkg::OUT_W-1:0]          force_z,
	output logic signed [fsd_pkg::OUT_W-1:0]          torque_x,
	output logic signed [fsd_pkg::OUT_W-1:0]          torque_y,
	output logic signed [fsd_pkg::OUT_W-1:0]          torque_z,
	output logic                                      saturated
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int USED_CH = (CHANNELS < fsd_pkg::COUNT_FIELDS) ? CHANNELS
		: fsd_pkg::COUNT_FIELDS;
	localparam int CB_IN   = (COUNT_BITS < fsd_pkg::COUNT_IN_W) ? COUNT_BITS
		: fsd_pkg::COUNT_IN_W;
	localparam int W_W     = COUNT_BITS + 1 + fsd_pkg::VALUE_W + fsd_pkg::GUARD_W
		- fsd_pkg::FRAC_DROP;
	localparam int ZBASE   = fsd_pkg::AXES * CHANNELS;

	// Engine (read issue) state.
	logic                      busy_q;
	logic [CH_W-1:0]           ch_q;
	fsd_pkg::func_t            func_q;
	logic [COUNT_BITS-1:0]     counts_q [USED_CH];
	logic [1:0]                inflight_q;

	logic                      in_fire;
	logic                      out_fire;
	logic                      last_rd;
	logic                      load_wr;
	logic                      zero_hit;
	logic [fsd_pkg::INDEX_W-1:0] zero_off;
	logic [fsd_pkg::COUNT_IN_W-1:0] count_port [fsd_pkg::COUNT_FIELDS];

	// Stage registers.
	logic                      vld_s1, first_s1, last_s1;
	fsd_pkg::func_t            func_s1;
	logic [COUNT_BITS-1:0]     cnt_s1;
	logic [COUNT_BITS-1:0]     zero_rd;
	logic                      vld_s2, first_s2, last_s2;
	fsd_pkg::func_t            func_s2;
	logic signed [COUNT_BITS:0] diff_s2;
	fsd_pkg::lane_ctl_t        ctl_s3;
	fsd_pkg::func_t            func_s3;
	logic                      s4_vld_q;
	fsd_pkg::func_t            func_s4;
	logic                      s4_load;
	logic                      s4_take;

	logic signed [W_W-1:0]             w_s4   [fsd_pkg::AXES];
	logic signed [fsd_pkg::OUT_W-1:0]  wrench [fsd_pkg::AXES];

	assign count_port[0] = count_ch0;
	assign count_port[1] = count_ch1;
	assign count_port[2] = count_ch2;
	assign count_port[3] = count_ch3;
	assign count_port[4] = count_ch4;
	assign count_port[5] = count_ch5;

	assign last_rd  = busy_q && (ch_q == CH_W'(USED_CH - 1));
	assign in_ready = (!busy_q || last_rd) && (inflight_q < 2'd2);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign load_wr  = in_fire && (fsd_pkg::func_t'(func) == fsd_pkg::FUNC_LOAD);

	assign zero_hit = load_wr
		&& (table_index >= fsd_pkg::INDEX_W'(ZBASE))
		&& (table_index < fsd_pkg::INDEX_W'(ZBASE + CHANNELS));
	assign zero_off = table_index - fsd_pkg::INDEX_W'(ZBASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			ch_q       <= '0;
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_fire) - 2'(out_fire);
			if (in_fire) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (last_rd) begin
				busy_q <= 1'b0;
				ch_q   <= '0;
			end else if (busy_q) begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= fsd_pkg::func_t'(func);
			for (int c = 0; c < USED_CH; c++) begin
				counts_q[c] <= COUNT_BITS'(count_port[c][CB_IN-1:0]);
			end
		end
	end

	fsd_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(CHANNELS)
	) u_zero_ram (
		.clk    (clk),
		.wr_en  (zero_hit),
		.wr_addr(zero_off[CH_W-1:0]),
		.wr_data(table_value[COUNT_BITS-1:0]),
		.rd_addr(ch_q),
		.rd_data(zero_rd)
	);

	// Control through the read, subtract and multiply stages, and the valid flag of the held finished word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			ctl_s3   <= '0;
			s4_vld_q <= 1'b0;
		end else begin
			vld_s1     <= busy_q;
			vld_s2     <= vld_s1;
			ctl_s3.vld <= vld_s2;
			if (s4_load) begin
				s4_vld_q <= 1'b1;
			end else if (s4_take) begin
				s4_vld_q <= 1'b0;
			end
			ctl_s3.first <= first_s2;
			ctl_s3.last  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (ch_q == '0);
		last_s1  <= last_rd;
		func_s1  <= func_q;
		cnt_s1   <= counts_q[ch_q];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		func_s2  <= func_s1;
		diff_s2  <= $signed({1'b0, cnt_s1}) - $signed({1'b0, zero_rd});
		func_s3  <= func_s2;
		if (s4_load) begin
			func_s4 <= func_s3;
		end
	end

	assign s4_load = ctl_s3.vld && ctl_s3.last;

	for (genvar a = 0; a < fsd_pkg::AXES; a++) begin : g_lane
		fsd_lane #(
			.CHANNELS  (CHANNELS),
			.COUNT_BITS(COUNT_BITS),
			.LANE      (a)
		) u_lane (
			.clk     (clk),
			.wr_en   (load_wr),
			.wr_index(table_index),
			.wr_value(table_value),
			.rd_addr (ch_q),
			.diff_s2 (diff_s2),
			.ctl_s3  (ctl_s3),
			.w_s4    (w_s4[a])
		);
	end

	fsd_merge #(
		.COUNT_BITS(COUNT_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s4_vld   (s4_vld_q),
		.s4_func  (func_s4),
		.w_s4     (w_s4),
		.s4_take  (s4_take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wrench_q (wrench),
		.saturated(saturated)
	);

	assign force_x  = wrench[0];
	assign force_y  = wrench[1];
	assign force_z  = wrench[2];
	assign torque_x = wrench[3];
	assign torque_y = wrench[4];
	assign torque_z = wrench[5];

	// A finished word never lands on a held word that the output side has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(s4_load && s4_vld_q && !s4_take))
		else $error("finished word overwrote a held word");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("more than two words in flight");

	a_engine_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last_rd) |=> (busy_q && (ch_q == $past(ch_q) + CH_W'(1))))
		else $error("engine stopped before its last column");

endmodule

`default_nettype wire

// ===== hw/rtl/fsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 6,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [WIDTH-1:0]       wr_data,
	input  wire logic [AW-1:0]          rd_addr,
	output logic      [WIDTH-1:0]       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fsd_lane.sv =====
// One axis lane: its row of coefficients, a multiplier and an accumulator.
// Depends on fsd_pkg and fsd_ram.
`default_nettype none

module fsd_lane #(
	parameter int CHANNELS   = fsd_pkg::CHANNELS_DEF,
	parameter int COUNT_BITS = fsd_pkg::COUNT_BITS_DEF,
	parameter int LANE       = 0,
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int W_W       = COUNT_BITS + 1 + fsd_pkg::VALUE_W + fsd_pkg::GUARD_W
		- fsd_pkg::FRAC_DROP
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [fsd_pkg::INDEX_W-1:0]            wr_index,
	input  wire logic [fsd_pkg::VALUE_W-1:0]            wr_value,
	input  wire logic [CH_W-1:0]                        rd_addr,
	input  wire logic signed [COUNT_BITS:0]             diff_s2,
	input  wire fsd_pkg::lane_ctl_t                     ctl_s3,
	output logic signed [W_W-1:0]                       w_s4
);

	localparam int PROD_W = COUNT_BITS + 1 + fsd_pkg::VALUE_W;
	localparam int ACC_W  = PROD_W + fsd_pkg::GUARD_W;
	localparam int BASE   = LANE * CHANNELS;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (fsd_pkg::FRAC_DROP - 1);

	logic                              hit;
	logic [fsd_pkg::INDEX_W-1:0]       offset;
	logic [fsd_pkg::VALUE_W-1:0]       coef_rd;
	logic signed [fsd_pkg::VALUE_W-1:0] coef_s2;
	logic signed [PROD_W-1:0]          prod_c;
	logic signed [PROD_W-1:0]          prod_s3;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [ACC_W-1:0]           base;
	logic signed [ACC_W-1:0]           sum;

	assign hit = wr_en
		&& (wr_index >= fsd_pkg::INDEX_W'(BASE))
		&& (wr_index < fsd_pkg::INDEX_W'(BASE + CHANNELS));
	assign offset = wr_index - fsd_pkg::INDEX_W'(BASE);

	fsd_ram #(
		.WIDTH(fsd_pkg::VALUE_W),
		.DEPTH(CHANNELS)
	) u_coef_ram (
		.clk    (clk),
		.wr_en  (hit),
		.wr_addr(offset[CH_W-1:0]),
		.wr_data(wr_value),
		.rd_addr(rd_addr),
		.rd_data(coef_rd)
	);

	assign prod_c = diff_s2 * coef_s2;

	// The rounding half is folded in with the first product of each word.
	assign base = ctl_s3.first ? ROUND : acc_q;
	assign sum  = base + ACC_W'(prod_s3);

	always_ff @(posedge clk) begin
		coef_s2 <= coef_rd;
		prod_s3 <= prod_c;
		if (ctl_s3.vld) begin
			acc_q <= sum;
		end
		if (ctl_s3.vld && ctl_s3.last) begin
			w_s4 <= sum[ACC_W-1:fsd_pkg::FRAC_DROP];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fsd_merge.sv =====
// Merging stage: applies or captures the tare, saturates, and holds the output word.
// Depends on fsd_pkg.
`default_nettype none

module fsd_merge #(
	parameter int COUNT_BITS = fsd_pkg::COUNT_BITS_DEF,
	localparam int W_W = COUNT_BITS + 1 + fsd_pkg::VALUE_W + fsd_pkg::GUARD_W
		- fsd_pkg::FRAC_DROP
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s4_vld,
	input  wire fsd_pkg::func_t                     s4_func,
	input  wire logic signed [W_W-1:0]              w_s4 [fsd_pkg::AXES],
	output logic                                    s4_take,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [fsd_pkg::OUT_W-1:0]        wrench_q [fsd_pkg::AXES],
	output logic                                    saturated
);

	localparam int DW  = (W_W + 1 > fsd_pkg::OUT_W + 1) ? W_W + 1 : fsd_pkg::OUT_W + 1;
	localparam logic signed [fsd_pkg::OUT_W-1:0] SAT_MAX = {1'b0, {(fsd_pkg::OUT_W-1){1'b1}}};
	localparam logic signed [fsd_pkg::OUT_W-1:0] SAT_MIN = {1'b1, {(fsd_pkg::OUT_W-1){1'b0}}};

	logic signed [fsd_pkg::OUT_W-1:0] tare_q [fsd_pkg::AXES];
	logic signed [DW-1:0]             diff  [fsd_pkg::AXES];
	logic signed [fsd_pkg::OUT_W-1:0] clip_val [fsd_pkg::AXES];
	logic [fsd_pkg::AXES-1:0]         clip;
	logic                             is_tare;
	logic                             has_wrench;
	logic                             out_vld_q;

	assign is_tare    = (s4_func == fsd_pkg::FUNC_TARE);
	assign has_wrench = is_tare || (s4_func == fsd_pkg::FUNC_MEASURE);
	assign s4_take    = s4_vld && (!out_vld_q || out_ready);
	assign out_valid  = out_vld_q;

	always_comb begin
		for (int a = 0; a < fsd_pkg::AXES; a++) begin
			diff[a] = DW'(w_s4[a]) - (is_tare ? DW'(0) : DW'(tare_q[a]));
			// In range when every bit above the result's sign matches it.
			clip[a] = !((&diff[a][DW-1:fsd_pkg::OUT_W-1]) || !(|diff[a][DW-1:fsd_pkg::OUT_W-1]));
			if (clip[a]) begin
				clip_val[a] = diff[a][DW-1] ? SAT_MIN : SAT_MAX;
			end else begin
				clip_val[a] = diff[a][fsd_pkg::OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			for (int a = 0; a < fsd_pkg::AXES; a++) begin
				tare_q[a] <= '0;
			end
		end else begin
			if (s4_take) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (s4_take && is_tare) begin
				for (int a = 0; a < fsd_pkg::AXES; a++) begin
					tare_q[a] <= clip_val[a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s4_take) begin
			for (int a = 0; a < fsd_pkg::AXES; a++) begin
				wrench_q[a] <= has_wrench ? clip_val[a] : '0;
			end
			saturated <= has_wrench && (|clip);
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for force_torque_decoupling: table loads, tare, measure and no-op words.
// Depends on fsd_pkg and the force_torque_decoupling RTL; needs no other file.

module tb;

	localparam int CHANNELS      = fsd_pkg::CHANNELS_DEF;
	localparam int AXES          = fsd_pkg::AXES;
	localparam int FRAC_DROP     = fsd_pkg::FRAC_DROP;
	localparam int COEF_ENTRIES  = AXES * CHANNELS;
	localparam int TABLE_END     = COEF_ENTRIES + CHANNELS;
	localparam int RANDOM_ITEMS  = 320;
	localparam int IDLE_PCT      = 23;
	localparam int SETTLE_CYCLES = 20;
	localparam int RESET_CYCLES  = 6;
	localparam longint ROUND_HALF = longint'(1) << (FRAC_DROP - 1);
	localparam logic signed [31:0] SAT_HI = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_LO = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic               sat;
	} wrench_word_t;

	typedef enum {COUNTS_ANY, COUNTS_NEAR_ZERO, COUNTS_RAIL, COUNTS_AT_ZERO} count_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	fsd_pkg::func_t func = fsd_pkg::FUNC_NOP;
	logic [fsd_pkg::INDEX_W-1:0] table_index = '0;
	logic signed [fsd_pkg::VALUE_W-1:0] table_value = '0;
	logic [5:0][fsd_pkg::COUNT_IN_W-1:0] count = '0;

	wire in_ready;
	wire out_valid;
	wire signed [fsd_pkg::OUT_W-1:0] force_x, force_y, force_z, torque_x, torque_y, torque_z;
	wire saturated;

	// Predicted block state.
	logic signed [31:0] coef_tab [COEF_ENTRIES];
	logic [15:0] zero_cnt [CHANNELS];
	longint tare_w [AXES];

	wrench_word_t wrench_expected [$];

	int errors = 0;
	int n_checked = 0;
	int n_saturated = 0;
	int n_load = 0;
	int n_tare = 0;
	int n_measure = 0;
	int n_nop = 0;
	int n_random = 0;
	bit no_idle = 1'b0;
	int hold_request = 0;
	int hold_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	force_torque_decoupling uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.table_index(table_index),
		.table_value(table_value),
		.count_ch0(count[0]),
		.count_ch1(count[1]),
		.count_ch2(count[2]),
		.count_ch3(count[3]),
		.count_ch4(count[4]),
		.count_ch5(count[5]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.force_x(force_x),
		.force_y(force_y),
		.force_z(force_z),
		.torque_x(torque_x),
		.torque_y(torque_y),
		.torque_z(torque_z),
		.saturated(saturated)
	);

	function automatic logic signed [31:0] clip32(input longint x, inout bit clip);
		if (x > longint'(SAT_HI)) begin
			clip = 1'b1;
			return SAT_HI;
		end
		if (x < longint'(SAT_LO)) begin
			clip = 1'b1;
			return SAT_LO;
		end
		return x[31:0];
	endfunction

	// Updates the predicted state for one accepted word and returns its result word.
	function automatic wrench_word_t predict_wrench(input fsd_pkg::func_t f,
			input logic [5:0] idx, input logic [31:0] val, input logic [5:0][15:0] c);
		wrench_word_t r;
		logic signed [31:0] v [AXES];
		longint acc, diff, w;
		bit clip;
		clip = 1'b0;
		for (int a = 0; a < AXES; a++)
			v[a] = '0;
		case (f)
			fsd_pkg::FUNC_LOAD: begin
				if (idx < COEF_ENTRIES)
					coef_tab[idx] = val;
				else if (idx < TABLE_END)
					zero_cnt[idx - COEF_ENTRIES] = val[15:0];
			end
			fsd_pkg::FUNC_TARE, fsd_pkg::FUNC_MEASURE: begin
				for (int a = 0; a < AXES; a++) begin
					acc = 0;
					for (int ch = 0; ch < CHANNELS; ch++) begin
						diff = longint'(c[ch]) - longint'(zero_cnt[ch]);
						acc += diff * longint'(coef_tab[a * CHANNELS + ch]);
					end
					// Round half up from Q.24 to Q24.8; the shift is a floor.
					w = (acc + ROUND_HALF) >>> FRAC_DROP;
					if (f == fsd_pkg::FUNC_TARE) begin
						v[a] = clip32(w, clip);
						tare_w[a] = v[a];
					end else begin
						v[a] = clip32(w - tare_w[a], clip);
					end
				end
			end
			default: ;
		endcase
		r.fx = v[0];
		r.fy = v[1];
		r.fz = v[2];
		r.tx = v[3];
		r.ty = v[4];
		r.tz = v[5];
		r.sat = clip;
		return r;
	endfunction

	function automatic logic [31:0] realistic_coef();
		return 32'($urandom_range(134217727)) - 32'd67108864;
	endfunction

	function automatic logic [31:0] pick_coef();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return realistic_coef();
		if (r < 90)
			return $urandom;
		case ($urandom_range(3))
			0: return SAT_HI;
			1: return SAT_LO;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Zero words carry junk in the upper half, which the block must drop.
	function automatic logic [31:0] pick_zero();
		if ($urandom_range(9) < 7)
			return {16'($urandom), 16'(28768 + $urandom_range(8000))};
		return $urandom;
	endfunction

	function automatic logic [5:0][15:0] pick_counts(input count_mode_t m);
		logic [5:0][15:0] c;
		for (int ch = 0; ch < 6; ch++) begin
			case (m)
				COUNTS_NEAR_ZERO: c[ch] = zero_cnt[ch] + 16'($urandom_range(1000)) - 16'd500;
				COUNTS_RAIL: c[ch] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				COUNTS_AT_ZERO: c[ch] = zero_cnt[ch];
				default: c[ch] = 16'($urandom);
			endcase
		end
		return c;
	endfunction

	function automatic count_mode_t random_mode();
		int r;
		r = $urandom_range(9);
		if (r < 5)
			return COUNTS_NEAR_ZERO;
		if (r < 8)
			return COUNTS_ANY;
		return COUNTS_RAIL;
	endfunction

	task automatic send_word(input fsd_pkg::func_t f, input logic [5:0] idx,
			input logic [31:0] val, input logic [5:0][15:0] c);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		table_index <= idx;
		table_value <= val;
		count <= c;
		do @(posedge clk); while (!in_ready);
		wrench_expected.push_back(predict_wrench(f, idx, val, c));
		case (f)
			fsd_pkg::FUNC_LOAD: n_load++;
			fsd_pkg::FUNC_TARE: n_tare++;
			fsd_pkg::FUNC_MEASURE: n_measure++;
			default: n_nop++;
		endcase
	endtask

	task automatic load_word(input logic [5:0] idx, input logic [31:0] val);
		send_word(fsd_pkg::FUNC_LOAD, idx, val, pick_counts(COUNTS_ANY));
	endtask

	task automatic sense(input fsd_pkg::func_t f, input logic [5:0][15:0] c);
		send_word(f, 6'($urandom), $urandom, c);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (wrench_expected.size() != 0);
	endtask

	// Every entry is written here, so no later word reads an empty one.
	task automatic test_table_load();
		for (int i = 0; i < COEF_ENTRIES; i++)
			load_word(6'(i), realistic_coef());
		for (int ch = 0; ch < CHANNELS; ch++)
			load_word(6'(COEF_ENTRIES + ch), pick_zero());
		wait_results();
	endtask

	task automatic test_corner_words();
		logic [5:0][15:0] c;
		// The tare is still zero from reset.
		sense(fsd_pkg::FUNC_MEASURE, '0);
		sense(fsd_pkg::FUNC_MEASURE, '1);
		c = pick_counts(COUNTS_ANY);
		sense(fsd_pkg::FUNC_TARE, c);
		sense(fsd_pkg::FUNC_MEASURE, c);
		load_word(6'(TABLE_END), $urandom);
		load_word(6'h3F, $urandom);
		send_word(fsd_pkg::FUNC_NOP, 6'($urandom), $urandom, pick_counts(COUNTS_ANY));
		// Full-scale coefficients on two channels drive force x high and force y low.
		load_word(6'd0, SAT_HI);
		load_word(6'd1, SAT_HI);
		load_word(6'(CHANNELS), SAT_LO);
		load_word(6'(CHANNELS + 1), SAT_LO);
		load_word(6'(COEF_ENTRIES), 32'hFFFF_0064);
		load_word(6'(COEF_ENTRIES + 1), 32'h0);
		c = pick_counts(COUNTS_AT_ZERO);
		c[0] = 16'hFFFF;
		c[1] = 16'hFFFF;
		sense(fsd_pkg::FUNC_MEASURE, c);
		sense(fsd_pkg::FUNC_TARE, c);
		sense(fsd_pkg::FUNC_MEASURE, pick_counts(COUNTS_AT_ZERO));
		sense(fsd_pkg::FUNC_MEASURE, c);
		// Half an output step on force z checks round half up on both signs.
		load_word(6'(2 * CHANNELS), 32'h0000_8000);
		c = pick_counts(COUNTS_AT_ZERO);
		sense(fsd_pkg::FUNC_TARE, c);
		c[0] = zero_cnt[0] + 16'd1;
		sense(fsd_pkg::FUNC_MEASURE, c);
		c[0] = zero_cnt[0] - 16'd1;
		sense(fsd_pkg::FUNC_MEASURE, c);
		c[0] = zero_cnt[0] - 16'd3;
		sense(fsd_pkg::FUNC_MEASURE, c);
		wait_results();
	endtask

	task automatic test_backpressure();
		hold_request = 80;
		no_idle = 1'b1;
		repeat (12)
			sense(fsd_pkg::FUNC_MEASURE, pick_counts(COUNTS_NEAR_ZERO));
		no_idle = 1'b0;
		wait_results();
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		repeat (60)
			sense(($urandom_range(7) == 0) ? fsd_pkg::FUNC_TARE : fsd_pkg::FUNC_MEASURE,
				pick_counts(random_mode()));
		no_idle = 1'b0;
		wait_results();
	endtask

	task automatic test_random_stream();
		int r, a;
		logic [5:0] idx;
		for (int i = 0; i < COEF_ENTRIES; i++)
			load_word(6'(i), realistic_coef());
		for (int ch = 0; ch < CHANNELS; ch++)
			load_word(6'(COEF_ENTRIES + ch), pick_zero());
		while (n_random < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 65) begin
				if ($urandom_range(4) == 0) begin
					sense(fsd_pkg::FUNC_TARE, pick_counts(random_mode()));
					n_random++;
				end
				repeat ($urandom_range(10, 3)) begin
					sense(fsd_pkg::FUNC_MEASURE, pick_counts(random_mode()));
					n_random++;
				end
			end else if (r < 85) begin
				repeat ($urandom_range(6, 1)) begin
					idx = 6'($urandom_range(TABLE_END - 1));
					load_word(idx, (idx < COEF_ENTRIES) ? pick_coef() : pick_zero());
					n_random++;
				end
			end else if (r < 95) begin
				// Words the block ignores: out-of-range loads and no-ops.
				if ($urandom_range(1))
					load_word(6'($urandom_range(63, TABLE_END)), $urandom);
				else
					send_word(fsd_pkg::FUNC_NOP, 6'($urandom), $urandom,
						pick_counts(COUNTS_ANY));
			end else begin
				// A whole axis row at full scale, then back-to-back tares.
				a = $urandom_range(AXES - 1);
				for (int ch = 0; ch < CHANNELS; ch++)
					load_word(6'(a * CHANNELS + ch), $urandom_range(1) ? SAT_HI : SAT_LO);
				sense(fsd_pkg::FUNC_TARE, pick_counts(COUNTS_RAIL));
				sense(fsd_pkg::FUNC_TARE, pick_counts(random_mode()));
				sense(fsd_pkg::FUNC_MEASURE, pick_counts(COUNTS_RAIL));
				n_random += CHANNELS + 3;
			end
		end
		wait_results();
	endtask

	// Output side: random stalls, an idle-free mode and requested long hold-offs.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				$signed(want), $signed(got));
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		wrench_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (wrench_expected.size() == 0) begin
				$display("%0t: result word with nothing expected, force_x %0d", $time, force_x);
				errors++;
			end else begin
				want = wrench_expected.pop_front();
				check_field("force_x", want.fx, force_x);
				check_field("force_y", want.fy, force_y);
				check_field("force_z", want.fz, force_z);
				check_field("torque_x", want.tx, torque_x);
				check_field("torque_y", want.ty, torque_y);
				check_field("torque_z", want.tz, torque_z);
				check_field("saturated", 32'(want.sat), 32'(saturated));
				n_checked++;
				if (saturated)
					n_saturated++;
			end
		end
	end

	initial begin
		for (int i = 0; i < COEF_ENTRIES; i++)
			coef_tab[i] = '0;
		for (int ch = 0; ch < CHANNELS; ch++)
			zero_cnt[ch] = '0;
		for (int a = 0; a < AXES; a++)
			tare_w[a] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_corner_words();
		test_backpressure();
		test_full_rate();
		test_random_stream();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d loads, %0d tares, %0d measures and %0d no-ops.",
			n_load, n_tare, n_measure, n_nop);
		$display("Checked %0d result words, %0d of them clipped; %0d errors.",
			n_checked, n_saturated, errors);
		if (errors == 0 && wrench_expected.size() == 0)
			$display("PASS force_torque_decoupling");
		else
			$display("FAIL force_torque_decoupling");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL force_torque_decoupling");
		$finish;
	end

endmodule

// ===== force_torque_decoupling.f =====
hw/rtl/fsd_pkg.sv
hw/rtl/fsd_ram.sv
hw/rtl/fsd_lane.sv
hw/rtl/fsd_merge.sv
hw/rtl/force_torque_decoupling.sv
verif/tb.sv
